@@ rtl/ftf_pkg.sv @@
`timescale 1ns / 1ps
package ftf_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_HOPS_DEF    = 4;
    localparam int HOP_IDS_DEF     = 1024;

    localparam int KEY_W  = 64;
    localparam int HOP_W  = 10;
    localparam int CNT_W  = 3;
    localparam int ST_W   = 3;
    localparam int MODE_W = 3;
    localparam int DCNT_W = 4;
    localparam logic [DCNT_W-1:0] DOWN_MAX = 4'd15;

    localparam logic [MODE_W-1:0] M_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] M_UPDATE = 3'd1;
    localparam logic [MODE_W-1:0] M_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] M_FLUSH  = 3'd3;
    localparam logic [MODE_W-1:0] M_LOOKUP = 3'd4;
    localparam logic [MODE_W-1:0] M_HOP    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_DOWN  = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_COUNT = 3'd5;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic do_write;
        logic do_delete;
        logic clr_step;
        logic clr_start;
        logic dc_update;
        logic hop_start;
        logic hop_step;
        logic hop_wb;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic free_found;
        logic clr_last;
        logic hop_last;
        logic dc_zero;
        logic hop_range;
    } t_stat;
endpackage

@@ rtl/ftf_datapath.sv @@
`timescale 1ns / 1ps
module ftf_datapath
    import ftf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_HOPS    = MAX_HOPS_DEF,
    parameter int HOP_IDS     = HOP_IDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [KEY_W-1:0]  i_addr,
    input  logic [CNT_W-1:0]  i_hop_count,
    input  logic [HOP_W-1:0]  i_hop_0,
    input  logic [HOP_W-1:0]  i_hop_1,
    input  logic [HOP_W-1:0]  i_hop_2,
    input  logic [HOP_W-1:0]  i_hop_3,
    input  logic              i_hop_is_up,
    output t_stat             o_stat,
    output logic [HOP_W-1:0]  o_front
);
    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HW = (HOP_IDS > 1) ? $clog2(HOP_IDS) : 1;
    localparam int RW = HOP_W * MAX_HOPS;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];
    logic [RW-1:0]    hop_mem [TABLE_DEPTH];
    logic [HOP_W-1:0] pri_mem [TABLE_DEPTH];
    logic [DCNT_W-1:0] dc_mem [HOP_IDS];

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [RW-1:0]     r_hops_in;
    logic [HOP_W-1:0]  r_hop;
    logic              r_up;
    logic [SW:0]       r_idx;
    logic [SW-1:0]     r_slot;
    logic              r_found;
    logic              r_free;
    logic [SW-1:0]     r_free_slot;
    logic [HW:0]       r_clr;
    logic [DCNT_W-1:0] r_dc;
    logic [KEY_W-1:0]  r_rkey;
    logic [CNT_W-1:0]  r_rcnt;
    logic [RW-1:0]     r_rhops;
    logic [HOP_W-1:0]  r_rpri;
    logic              r_rval;
    logic              r_rd_ok;
    logic [SW-1:0]     r_rd_slot;
    logic [HOP_W-1:0]  r_front;
    logic [1:0]        r_hphase;

    wire [SW-1:0] idx_lo = r_idx[SW-1:0];
    wire [HW-1:0] hop_idx = r_hop[HW-1:0];
    wire hop_ok = ({{(32-HOP_W){1'b0}}, r_hop} < 32'(HOP_IDS));

    logic [RW-1:0] in_hops;
    always_comb begin
        logic [HOP_W-1:0] hv [4];
        hv[0] = i_hop_0; hv[1] = i_hop_1; hv[2] = i_hop_2; hv[3] = i_hop_3;
        in_hops = '0;
        for (int k = 0; k < MAX_HOPS; k++) begin
            if (k < 4 && 32'(k) < 32'(i_hop_count)) begin
                in_hops[k*HOP_W +: HOP_W] = hv[k & 3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_addr    <= i_addr;
            r_cnt     <= i_hop_count;
            r_hops_in <= in_hops;
            r_hop     <= i_hop_0;
            r_up      <= i_hop_is_up;
        end
    end

    // scan / walk read pipeline: address r_idx, data registered in the next cycle
    always_ff @(posedge i_clk) begin
        r_rkey  <= key_mem[idx_lo];
        r_rcnt  <= cnt_mem[idx_lo];
        r_rhops <= hop_mem[idx_lo];
        r_rpri  <= pri_mem[idx_lo];
        r_rval  <= r_valid[idx_lo];
        r_rd_slot <= idx_lo;
        r_dc    <= dc_mem[hop_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (i_cmd.scan_start || i_cmd.hop_start) begin
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_idx != (SW+1)'(TABLE_DEPTH)) r_idx <= r_idx + 1'b1;
                r_rd_ok <= (r_idx != (SW+1)'(TABLE_DEPTH));
                if (r_rd_ok && r_rval && r_rkey == r_addr && !r_found) begin
                    r_found <= 1'b1;
                    r_slot  <= r_rd_slot;
                end
                if (r_rd_ok && !r_rval && !r_free) begin
                    r_free      <= 1'b1;
                    r_free_slot <= r_rd_slot;
                end
            end else if (i_cmd.hop_step) begin
                if (r_hphase == 2'd0) r_rd_ok <= 1'b1;
                if (r_hphase == 2'd2) begin
                    r_idx   <= r_idx + 1'b1;
                    r_rd_ok <= 1'b0;
                end
            end
        end
    end

    // hop walk: phase 0 issue read, 1 data in, read down counts, 2 swap and write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hphase <= '0;
        end else if (i_cmd.hop_start) begin
            r_hphase <= '0;
        end else if (i_cmd.hop_step) begin
            r_hphase <= (r_hphase == 2'd2) ? 2'd0 : r_hphase + 1'b1;
        end
    end

    logic [DCNT_W-1:0] n_dc;
    always_comb begin
        if (r_up) n_dc = r_dc - 1'b1;
        else if (r_dc < DOWN_MAX) n_dc = r_dc + 1'b1;
        else n_dc = r_dc;
    end

    logic [MAX_HOPS-1:0] dn_cur;
    logic [HW-1:0] dn_addr [MAX_HOPS];
    always_comb begin
        for (int k = 0; k < MAX_HOPS; k++) begin
            dn_addr[k] = r_rhops[k*HOP_W +: HW];
        end
    end
    // per-hop down bits read from registered copies of down counts
    genvar g;
    generate
        for (g = 0; g < MAX_HOPS; g = g + 1) begin : g_dn
            logic [DCNT_W-1:0] r_dq;
            logic [DCNT_W-1:0] dc_shadow [HOP_IDS];
            always_ff @(posedge i_clk) begin
                if (i_cmd.dc_update) dc_shadow[hop_idx] <= n_dc;
                else if (i_cmd.clr_step) dc_shadow[r_clr[HW-1:0]] <= '0;
                r_dq <= dc_shadow[dn_addr[g]];
            end
            assign dn_cur[g] = (r_dq != '0) &&
                ({{(32-HOP_W){1'b0}}, r_rhops[g*HOP_W +: HOP_W]} < 32'(HOP_IDS));
        end
    endgenerate

    logic [RW-1:0] n_swap;
    always_comb begin
        logic hit;
        logic [HOP_W-1:0] h0, hk;
        int sel;
        hit = 1'b0;
        sel = 0;
        n_swap = r_rhops;
        h0 = r_rhops[0 +: HOP_W];
        for (int k = 0; k < MAX_HOPS; k++) begin
            if (!hit && 32'(k) < 32'(r_rcnt)) begin
                if (r_up ? (r_rhops[k*HOP_W +: HOP_W] == r_hop) : !dn_cur[k]) begin
                    hit = 1'b1;
                    sel = k;
                end
            end
        end
        hk = r_rhops[sel*HOP_W +: HOP_W];
        if (hit) begin
            n_swap[0 +: HOP_W] = hk;
            n_swap[sel*HOP_W +: HOP_W] = h0;
        end
        if (!r_rval) n_swap = r_rhops;
        else if (r_up && !(r_rpri == r_hop && h0 != r_hop)) n_swap = r_rhops;
        else if (!r_up && h0 != r_hop) n_swap = r_rhops;
    end

    wire [SW-1:0] wslot = (r_mode == M_ADD) ? r_free_slot : r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            key_mem[wslot] <= r_addr;
            cnt_mem[wslot] <= r_cnt;
            hop_mem[wslot] <= r_hops_in;
            pri_mem[wslot] <= r_hops_in[0 +: HOP_W];
        end else if (i_cmd.hop_wb && r_hphase == 2'd2) begin
            hop_mem[r_rd_slot] <= n_swap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.do_write) begin
            r_valid[wslot] <= 1'b1;
        end else if (i_cmd.do_delete) begin
            r_valid[r_slot] <= 1'b0;
        end else if (i_cmd.clr_start) begin
            r_valid <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dc_update) dc_mem[hop_idx] <= n_dc;
        else if (i_cmd.clr_step) dc_mem[r_clr[HW-1:0]] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_rd_ok && r_rval && r_rkey == r_addr && !r_found)
            r_front <= r_rhops[0 +: HOP_W];
    end

    assign o_front = r_front;
    assign o_stat.scan_last  = !r_rd_ok && (r_idx == (SW+1)'(TABLE_DEPTH));
    assign o_stat.found      = r_found;
    assign o_stat.free_found = r_free;
    assign o_stat.clr_last   = (r_clr == (HW+1)'(HOP_IDS - 1));
    assign o_stat.hop_last   = (r_hphase == 2'd2) && (r_idx == (SW+1)'(TABLE_DEPTH - 1));
    assign o_stat.dc_zero    = (r_dc == '0);
    assign o_stat.hop_range  = hop_ok;
endmodule

@@ rtl/ftf_ctrl.sv @@
`timescale 1ns / 1ps
module ftf_ctrl
    import ftf_pkg::*;
#(
    parameter int MAX_HOPS = MAX_HOPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CNT_W-1:0]  i_hop_count,
    input  logic              i_hop_is_up,
    input  t_stat             i_stat,
    input  logic [HOP_W-1:0]  i_front,
    output t_cmd              o_cmd,
    output logic              o_busy,
    output logic              o_done,
    output logic [ST_W-1:0]   o_status,
    output logic [HOP_W-1:0]  o_next_hop
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_DC   = 3'd3;
    localparam logic [2:0] S_DC2  = 3'd4;
    localparam logic [2:0] S_HOP  = 3'd5;
    localparam logic [2:0] S_INIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic r_up;
    logic r_done, n_done;
    logic [ST_W-1:0] r_st, n_st;
    logic [HOP_W-1:0] r_nh, n_nh;

    wire go = i_start && (r_state == S_IDLE);
    wire bad = (i_mode == M_ADD || i_mode == M_UPDATE) &&
               (i_hop_count == '0 || 32'(i_hop_count) > 32'(MAX_HOPS));

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        n_st = ST_OK;
        n_nh = '0;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (go) begin
                    o_cmd.load = 1'b1;
                    if (bad) begin
                        n_done = 1'b1; n_st = ST_BAD_COUNT;
                    end else if (i_mode == M_ADD || i_mode == M_UPDATE ||
                                 i_mode == M_DELETE || i_mode == M_LOOKUP) begin
                        o_cmd.scan_start = 1'b1; n_state = S_SCAN;
                    end else if (i_mode == M_FLUSH) begin
                        o_cmd.clr_start = 1'b1; n_state = S_CLR;
                    end else if (i_mode == M_HOP) begin
                        n_state = S_DC;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_IDLE; n_done = 1'b1;
                    case (r_mode)
                        M_ADD: begin
                            if (i_stat.found) n_st = ST_PRESENT;
                            else if (!i_stat.free_found) n_st = ST_FULL;
                            else o_cmd.do_write = 1'b1;
                        end
                        M_UPDATE: begin
                            if (!i_stat.found) n_st = ST_NOT_FOUND;
                            else o_cmd.do_write = 1'b1;
                        end
                        M_DELETE: begin
                            if (!i_stat.found) n_st = ST_NOT_FOUND;
                            else o_cmd.do_delete = 1'b1;
                        end
                        default: begin
                            if (!i_stat.found) n_st = ST_NOT_FOUND;
                            else n_nh = i_front;
                        end
                    endcase
                    o_cmd.scan_step = 1'b0;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE; n_done = 1'b1;
                end
            end
            // down-count sweep after reset, no result
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_DC: n_state = S_DC2;
            S_DC2: begin
                if (!i_stat.hop_range || (r_up && i_stat.dc_zero)) begin
                    n_state = S_IDLE; n_done = 1'b1; n_st = ST_NOT_DOWN;
                end else begin
                    o_cmd.dc_update = 1'b1;
                    o_cmd.hop_start = 1'b1;
                    n_state = S_HOP;
                end
            end
            S_HOP: begin
                o_cmd.hop_step = 1'b1;
                o_cmd.hop_wb = 1'b1;
                if (i_stat.hop_last) begin
                    n_state = S_IDLE; n_done = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        if (go) begin
            r_mode <= i_mode;
            r_up   <= i_hop_is_up;
        end
        r_st <= n_st;
        r_nh <= n_nh;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_st;
    assign o_next_hop = r_nh;
endmodule

@@ rtl/forwarding_table_with_failover_core.sv @@
`timescale 1ns / 1ps
// Lookup/add/update/delete run a linear key scan; flush runs a down-count
// clearing sweep; a hop event walks the whole table unless it is refused. A bad
// hop count or an unused mode is answered without a scan.
// Throughput: one request at a time; start is taken while busy is low.
// Result shown on o_done for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears valid bits, then busy stays high during
// a sweep that zeroes the down counts.
module forwarding_table_with_failover_core
    import ftf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_HOPS    = MAX_HOPS_DEF,
    parameter int HOP_IDS     = HOP_IDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [KEY_W-1:0]  i_addr,
    input  logic [CNT_W-1:0]  i_hop_count,
    input  logic [HOP_W-1:0]  i_hop_0,
    input  logic [HOP_W-1:0]  i_hop_1,
    input  logic [HOP_W-1:0]  i_hop_2,
    input  logic [HOP_W-1:0]  i_hop_3,
    input  logic              i_hop_is_up,
    output logic              o_done,
    output logic [ST_W-1:0]   o_status,
    output logic [HOP_W-1:0]  o_next_hop
);
    t_cmd cmd;
    t_stat stat;
    logic [HOP_W-1:0] front;

    ftf_ctrl #(.MAX_HOPS(MAX_HOPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_mode, .i_hop_count, .i_hop_is_up,
        .i_stat(stat), .i_front(front), .o_cmd(cmd), .o_busy(busy),
        .o_done, .o_status, .o_next_hop
    );

    ftf_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_HOPS(MAX_HOPS),
                   .HOP_IDS(HOP_IDS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_mode, .i_addr, .i_hop_count,
        .i_hop_0, .i_hop_1, .i_hop_2, .i_hop_3, .i_hop_is_up,
        .o_stat(stat), .o_front(front)
    );
endmodule

@@ rtl/ftf_checker.sv @@
`timescale 1ns / 1ps
module ftf_checker
    import ftf_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_done,
    input logic [ST_W-1:0] o_status,
    input logic [HOP_W-1:0] o_next_hop
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done)) else $error("request lost");
    a_nh_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_next_hop == '0)) else $error("hop on error");
    a_st_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_BAD_COUNT)) else $error("bad status");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
endmodule

bind forwarding_table_with_failover_core ftf_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_status, .o_next_hop
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import ftf_pkg::*;

    localparam int  DEPTH      = TABLE_DEPTH_DEF;
    localparam int  NHOPS      = MAX_HOPS_DEF;
    localparam int  NIDS       = HOP_IDS_DEF;
    localparam int  PHASE_REQS = 300;
    localparam int  FILL_REQS  = 262;
    localparam int  DRAIN_WAIT = 3 * DEPTH + 20;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  addr;
        logic [CNT_W-1:0]  cnt;
        logic [HOP_W-1:0]  hop [4];
        logic              up;
        logic              typed;
        logic [ST_W-1:0]   st;
        logic [HOP_W-1:0]  nh;
    } t_req;

    typedef struct {
        logic [ST_W-1:0]  st;
        logic [HOP_W-1:0] nh;
    } t_resp;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [MODE_W-1:0] i_mode = '0;
    logic [KEY_W-1:0]  i_addr = '0;
    logic [CNT_W-1:0]  i_hop_count = '0;
    logic [HOP_W-1:0]  i_hop_0 = '0;
    logic [HOP_W-1:0]  i_hop_1 = '0;
    logic [HOP_W-1:0]  i_hop_2 = '0;
    logic [HOP_W-1:0]  i_hop_3 = '0;
    logic              i_hop_is_up = 1'b0;
    logic              o_done;
    logic [ST_W-1:0]   o_status;
    logic [HOP_W-1:0]  o_next_hop;

    forwarding_table_with_failover_core DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table mirror
    logic             tbl_valid [DEPTH];
    logic [KEY_W-1:0] tbl_key   [DEPTH];
    int               tbl_cnt   [DEPTH];
    logic [HOP_W-1:0] tbl_hops  [DEPTH][NHOPS];
    logic [HOP_W-1:0] tbl_prim  [DEPTH];
    int               hop_down  [NIDS];

    t_resp        pending_resp [$];
    int           errors = 0;
    longint       cycles = 0;
    int           idle_pct = 0;
    logic [KEY_W-1:0] key_pool [32];

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void store_entry(int s, t_req r);
        tbl_valid[s] = 1'b1;
        tbl_key[s]   = r.addr;
        tbl_cnt[s]   = int'(r.cnt);
        for (int i = 0; i < NHOPS; i++)
            tbl_hops[s][i] = (i < r.cnt) ? r.hop[i] : '0;
        tbl_prim[s] = tbl_hops[s][0];
    endfunction

    function automatic void swap_to_front(int s, int i);
        logic [HOP_W-1:0] t;
        t = tbl_hops[s][0];
        tbl_hops[s][0] = tbl_hops[s][i];
        tbl_hops[s][i] = t;
    endfunction

    function automatic t_resp forward_step(t_req r);
        t_resp res;
        int    s;
        logic [HOP_W-1:0] h;
        res.st = ST_OK;
        res.nh = '0;
        h = r.hop[0];
        if ((r.mode == M_ADD || r.mode == M_UPDATE) && (r.cnt == 0 || r.cnt > NHOPS)) begin
            res.st = ST_BAD_COUNT;
        end else if (r.mode == M_ADD) begin
            if (find_key(r.addr) >= 0) begin
                res.st = ST_PRESENT;
            end else begin
                s = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!tbl_valid[i]) begin
                        s = i;
                        break;
                    end
                if (s < 0) res.st = ST_FULL;
                else store_entry(s, r);
            end
        end else if (r.mode == M_UPDATE) begin
            s = find_key(r.addr);
            if (s < 0) res.st = ST_NOT_FOUND;
            else store_entry(s, r);
        end else if (r.mode == M_DELETE) begin
            s = find_key(r.addr);
            if (s < 0) res.st = ST_NOT_FOUND;
            else tbl_valid[s] = 1'b0;
        end else if (r.mode == M_FLUSH) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            foreach (hop_down[i]) hop_down[i] = 0;
        end else if (r.mode == M_LOOKUP) begin
            s = find_key(r.addr);
            if (s < 0) res.st = ST_NOT_FOUND;
            else res.nh = tbl_hops[s][0];
        end else if (r.mode == M_HOP) begin
            if (r.up && hop_down[h] == 0) begin
                res.st = ST_NOT_DOWN;
            end else begin
                if (r.up) hop_down[h]--;
                else if (hop_down[h] < DOWN_MAX) hop_down[h]++;
                for (int e = 0; e < DEPTH; e++) begin
                    if (!tbl_valid[e]) continue;
                    if (r.up) begin
                        if (tbl_prim[e] == h && tbl_hops[e][0] != h)
                            for (int i = 0; i < tbl_cnt[e]; i++)
                                if (tbl_hops[e][i] == h) begin
                                    swap_to_front(e, i);
                                    break;
                                end
                    end else if (tbl_hops[e][0] == h) begin
                        for (int i = 0; i < tbl_cnt[e]; i++)
                            if (hop_down[tbl_hops[e][i]] == 0) begin
                                swap_to_front(e, i);
                                break;
                            end
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic issue(t_req r);
        t_resp pred;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        start       <= 1'b1;
        i_mode      <= r.mode;
        i_addr      <= r.addr;
        i_hop_count <= r.cnt;
        i_hop_0     <= r.hop[0];
        i_hop_1     <= r.hop[1];
        i_hop_2     <= r.hop[2];
        i_hop_3     <= r.hop[3];
        i_hop_is_up <= r.up;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        pred = forward_step(r);
        if (r.typed) begin
            if (pred.st != r.st || pred.nh != r.nh)
                report($sformatf("table row disagrees with prediction mode %0d", r.mode));
            pred.st = r.st;
            pred.nh = r.nh;
        end
        pending_resp.push_back(pred);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [HOP_W-1:0] pick_hop();
        case ($urandom_range(9))
            0: return HOP_W'($urandom);
            1: return '1;
            default: return HOP_W'($urandom_range(7));
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   p;
        r.typed = 1'b0;
        r.st = '0;
        r.nh = '0;
        p = $urandom_range(99);
        if (p < 20) r.mode = M_ADD;
        else if (p < 30) r.mode = M_UPDATE;
        else if (p < 40) r.mode = M_DELETE;
        else if (p < 42) r.mode = M_FLUSH;
        else if (p < 65) r.mode = M_LOOKUP;
        else if (p < 98) r.mode = M_HOP;
        else r.mode = MODE_W'($urandom_range(6, 7));
        r.addr = ($urandom_range(9) < 8) ? key_pool[$urandom_range(31)]
                                         : {$urandom, $urandom};
        r.cnt = ($urandom_range(9) < 8) ? CNT_W'($urandom_range(1, NHOPS))
                                        : CNT_W'($urandom);
        foreach (r.hop[i]) r.hop[i] = pick_hop();
        r.up = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic t_req mk(logic [MODE_W-1:0] m, logic [KEY_W-1:0] a, int c,
                                int h0, int h1, int h2, int h3, bit up,
                                logic [ST_W-1:0] st, int nh);
        t_req r;
        r.mode = m;
        r.addr = a;
        r.cnt = CNT_W'(c);
        r.hop[0] = HOP_W'(h0);
        r.hop[1] = HOP_W'(h1);
        r.hop[2] = HOP_W'(h2);
        r.hop[3] = HOP_W'(h3);
        r.up = up;
        r.typed = 1'b1;
        r.st = st;
        r.nh = HOP_W'(nh);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_done) begin
            if (pending_resp.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                exp_r = pending_resp.pop_front();
                if (o_status !== exp_r.st)
                    report($sformatf("status %0d, want %0d", o_status, exp_r.st));
                if (o_next_hop !== exp_r.nh)
                    report($sformatf("next_hop %0d, want %0d", o_next_hop, exp_r.nh));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_req rows [$];
        t_req r;
        logic [KEY_W-1:0] ones;
        ones = '1;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        foreach (hop_down[i]) hop_down[i] = 0;
        key_pool[0] = '0;
        key_pool[1] = ones;
        for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};

        // down counts are zero out of reset
        rows.push_back(mk(M_HOP,    0,    0, 9, 0, 0, 0, 1, ST_NOT_DOWN, 0));
        rows.push_back(mk(M_FLUSH,  0,    0, 0, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, 0,    1, 0, 0, 0, 0, 0, ST_NOT_FOUND, 0));
        rows.push_back(mk(M_ADD,    0,    0, 1, 0, 0, 0, 0, ST_BAD_COUNT, 0));
        rows.push_back(mk(M_ADD,    0,    5, 1, 0, 0, 0, 0, ST_BAD_COUNT, 0));
        rows.push_back(mk(M_UPDATE, 0,    7, 1, 0, 0, 0, 0, ST_BAD_COUNT, 0));
        rows.push_back(mk(M_UPDATE, 0,    2, 1, 2, 0, 0, 0, ST_NOT_FOUND, 0));
        rows.push_back(mk(M_DELETE, 0,    1, 0, 0, 0, 0, 0, ST_NOT_FOUND, 0));
        rows.push_back(mk(M_ADD,    0,    4, 1, 2, 3, 4, 0, ST_OK, 0));
        rows.push_back(mk(M_ADD,    ones, 1, 1023, 1023, 1023, 1023, 1, ST_OK, 0));
        rows.push_back(mk(M_ADD,    0,    1, 7, 0, 0, 0, 0, ST_PRESENT, 0));
        rows.push_back(mk(M_LOOKUP, 0,    0, 0, 0, 0, 0, 0, ST_OK, 1));
        rows.push_back(mk(M_LOOKUP, ones, 0, 0, 0, 0, 0, 0, ST_OK, 1023));
        rows.push_back(mk(M_HOP,    0,    0, 1, 0, 0, 0, 1, ST_NOT_DOWN, 0));
        rows.push_back(mk(M_HOP,    0,    0, 1, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, 0,    0, 0, 0, 0, 0, 0, ST_OK, 2));
        rows.push_back(mk(M_HOP,    0,    0, 2, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, 0,    0, 0, 0, 0, 0, 0, ST_OK, 3));
        // up while another hop is still down: primary returns anyway
        rows.push_back(mk(M_HOP,    0,    0, 1, 0, 0, 0, 1, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, 0,    0, 0, 0, 0, 0, 0, ST_OK, 1));
        // single-hop entry with its only hop down keeps its order
        rows.push_back(mk(M_HOP,    0,    0, 1023, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, ones, 0, 0, 0, 0, 0, 0, ST_OK, 1023));
        rows.push_back(mk(M_UPDATE, 0,    2, 5, 6, 0, 0, 0, ST_OK, 0));
        rows.push_back(mk(M_LOOKUP, 0,    0, 0, 0, 0, 0, 0, ST_OK, 5));
        rows.push_back(mk(3'd7,     ones, 7, 1023, 1023, 1023, 1023, 1, ST_OK, 0));
        rows.push_back(mk(M_DELETE, 0,    0, 0, 0, 0, 0, 0, ST_OK, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 48 : 0;
            if (ph == 0)
                foreach (rows[i]) issue(rows[i]);
            for (int n = 0; n < PHASE_REQS; n++) begin
                r = rand_req();
                if (ph == 1 && n < FILL_REQS) begin
                    // fill the table past capacity
                    r.mode = M_ADD;
                    r.addr = {$urandom, 24'hC0FFEE, 8'(n)};
                    r.cnt = CNT_W'($urandom_range(1, NHOPS));
                end else if (ph == 2 && n < 17) begin
                    // push one hop's down count into saturation
                    r.mode = M_HOP;
                    r.hop[0] = HOP_W'(3);
                    r.up = 1'b0;
                end
                issue(r);
            end
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ forwarding_table_with_failover_core.f @@
rtl/ftf_pkg.sv
rtl/ftf_datapath.sv
rtl/ftf_ctrl.sv
rtl/forwarding_table_with_failover_core.sv
rtl/ftf_checker.sv
verif/tb_top.sv
